// File: hdl/lmed_pkg.sv
package lmed_pkg;

    // Module count default and limits
    localparam int MODULES_DEFAULT = 32;
    localparam int MOD_W           = 5;

    // Field layout of the first word of an event
    localparam int EVLEN_W     = 13;
    localparam int HDLEN_W     = 5;
    localparam int EVLEN_SHIFT = 17;
    localparam int HDLEN_SHIFT = 12;

    localparam logic [31:0] EVLEN_MASK = 32'h3FFE_0000;
    localparam logic [31:0] HDLEN_MASK = 32'h0001_F000;
    localparam logic [31:0] KEEP_MASK  = 32'h8001_FFFF;
    localparam logic [31:0] LOW16_MASK = 32'h0000_FFFF;

    // Timestamp widths
    localparam int RAW_TIME_W    = 48;
    localparam int SCALED_TIME_W = 52;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // What the back end does to a forwarded word
    typedef enum logic [1:0] {
        OP_FORWARD,
        OP_REWRITE_LEN,
        OP_MASK_LOW16,
        OP_BAD_HEADER
    } lmed_op_t;

    // One queued word
    typedef struct packed {
        logic [MOD_W-1:0]      module_id;
        logic [31:0]           word;
        lmed_op_t              op;
        logic                  last;
        logic [RAW_TIME_W-1:0] raw_time;
        logic                  factor_eight;
    } lmed_entry_t;

endpackage

// File: hdl/lmed_front.sv
module lmed_front
    import lmed_pkg::*;
#(
    parameter int MODULES = MODULES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [MOD_W-1:0]  source_module,
    input  logic [31:0]       data_word,
    input  logic [31:0]       factor_eight_mask,
    output logic              emit,
    output lmed_entry_t       entry
);

    localparam int IDX_W = (MODULES > 1) ? $clog2(MODULES) : 1;

    // Per-module framing state
    logic [EVLEN_W-1:0] pos_reg   [MODULES];
    logic [EVLEN_W-1:0] ev_reg    [MODULES];
    logic [HDLEN_W-1:0] hd_reg    [MODULES];
    logic [31:0]        tlo_reg   [MODULES];
    logic [15:0]        thi_reg   [MODULES];

    logic [EVLEN_W-1:0] pos_next;
    logic [EVLEN_W-1:0] ev_next;
    logic [HDLEN_W-1:0] hd_next;
    logic [31:0]        tlo_next;
    logic [15:0]        thi_next;

    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic [EVLEN_W-1:0] pos;
    logic [EVLEN_W-1:0] ev;
    logic [HDLEN_W-1:0] hd;
    logic [EVLEN_W-1:0] ev_in;
    logic [HDLEN_W-1:0] hd_in;
    logic               bad;
    logic [EVLEN_W:0]   pos_plus;
    logic               hit;

    assign idx      = source_module[IDX_W-1:0];
    assign in_range = ({1'b0, source_module} < (MOD_W + 1)'(MODULES));
    assign pos      = pos_reg[idx];
    assign ev       = ev_reg[idx];
    assign hd       = hd_reg[idx];
    assign ev_in    = EVLEN_W'((data_word & EVLEN_MASK) >> EVLEN_SHIFT);
    assign hd_in    = HDLEN_W'((data_word & HDLEN_MASK) >> HDLEN_SHIFT);
    assign bad      = (ev_in == '0) || ({{(EVLEN_W-HDLEN_W){1'b0}}, hd_in} > ev_in);
    assign pos_plus = {1'b0, pos} + (EVLEN_W + 1)'(1);

    // Classify the word and work out the module's next state
    always_comb
    begin
        pos_next = pos;
        ev_next  = ev;
        hd_next  = hd;
        tlo_next = tlo_reg[idx];
        thi_next = thi_reg[idx];
        hit      = 1'b0;

        entry.module_id    = source_module;
        entry.word         = data_word;
        entry.op           = OP_FORWARD;
        entry.last         = 1'b0;
        entry.factor_eight = factor_eight_mask[source_module];

        if (pos == '0)
        begin
            if (bad)
            begin
                hit      = 1'b1;
                entry.op = OP_BAD_HEADER;
            end
            else
            begin
                ev_next    = ev_in;
                hd_next    = hd_in;
                tlo_next   = '0;
                thi_next   = '0;
                pos_next   = (ev_in == EVLEN_W'(1)) ? '0 : EVLEN_W'(1);
                hit        = (hd_in != '0);
                entry.last = (hd_in == HDLEN_W'(1));
                if (ev_in != {{(EVLEN_W-HDLEN_W){1'b0}}, hd_in})
                begin
                    entry.op = OP_REWRITE_LEN;
                end
            end
        end
        else
        begin
            // Advance, wrapping to a new first word at the event end
            pos_next = (pos_plus >= {1'b0, ev}) ? '0 : pos_plus[EVLEN_W-1:0];
            if (pos < {{(EVLEN_W-HDLEN_W){1'b0}}, hd})
            begin
                hit = 1'b1;
                if (pos == EVLEN_W'(1))
                begin
                    tlo_next = data_word;
                end
                else if (pos == EVLEN_W'(2))
                begin
                    thi_next = data_word[15:0];
                end
                else if ((pos == EVLEN_W'(3)) &&
                         (ev != {{(EVLEN_W-HDLEN_W){1'b0}}, hd}))
                begin
                    entry.op = OP_MASK_LOW16;
                end
                entry.last = (pos_plus == {{(EVLEN_W+1-HDLEN_W){1'b0}}, hd});
            end
        end

        entry.raw_time = {thi_next, tlo_next};
    end

    assign emit = hit && in_range;

    // State update on every accepted word of an in-range module
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MODULES; i++)
            begin
                pos_reg[i] <= '0;
                ev_reg[i]  <= '0;
                hd_reg[i]  <= '0;
                tlo_reg[i] <= '0;
                thi_reg[i] <= '0;
            end
        end
        else if (accept && in_range)
        begin
            pos_reg[idx] <= pos_next;
            ev_reg[idx]  <= ev_next;
            hd_reg[idx]  <= hd_next;
            tlo_reg[idx] <= tlo_next;
            thi_reg[idx] <= thi_next;
        end
    end

endmodule

// File: hdl/lmed_queue.sv
module lmed_queue
    import lmed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  lmed_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output lmed_entry_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lmed_entry_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hdl/lmed_back.sv
module lmed_back
    import lmed_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  lmed_entry_t              q_head,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [MOD_W-1:0]         out_module,
    output logic [31:0]              header_word,
    output logic                     header_last,
    output logic [SCALED_TIME_W-1:0] scaled_time,
    output logic                     bad_header
);

    logic                     valid_reg;
    logic [MOD_W-1:0]         module_reg;
    logic [31:0]              word_reg;
    logic                     last_reg;
    logic [SCALED_TIME_W-1:0] time_reg;
    logic                     bad_reg;

    logic [31:0]              word_next;
    logic [SCALED_TIME_W-1:0] time8;
    logic [SCALED_TIME_W-1:0] time_next;

    assign q_pop = q_valid && (!valid_reg || out_ready);

    // Word rewrite for stripped traces
    always_comb
    begin
        case (q_head.op)
            OP_REWRITE_LEN:
                word_next = (q_head.word & KEEP_MASK) |
                            {10'b0, q_head.word[HDLEN_SHIFT +: HDLEN_W], 17'b0};
            OP_MASK_LOW16:
                word_next = q_head.word & LOW16_MASK;
            default:
                word_next = q_head.word;
        endcase
    end

    // Timestamp scaling: x8 is a shift, x10 is x8 plus x2
    assign time8 = {1'b0, q_head.raw_time, 3'b0};
    always_comb
    begin
        if (!q_head.last)
        begin
            time_next = '0;
        end
        else if (q_head.factor_eight)
        begin
            time_next = time8;
        end
        else
        begin
            time_next = time8 + {3'b0, q_head.raw_time, 1'b0};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            module_reg <= q_head.module_id;
            word_reg   <= word_next;
            last_reg   <= q_head.last;
            time_reg   <= time_next;
            bad_reg    <= (q_head.op == OP_BAD_HEADER);
        end
    end

    assign out_valid   = valid_reg;
    assign out_module  = module_reg;
    assign header_word = word_reg;
    assign header_last = last_reg;
    assign scaled_time = time_reg;
    assign bad_header  = bad_reg;

endmodule

// File: hdl/list_mode_event_deframer_top.sv
// Channel   Handshake              Word contents
// input     in_valid / in_ready    source_module, data_word
// output    out_valid / out_ready  out_module, header_word, header_last,
//                                  scaled_time, bad_header
// config    cfg_wr_en              cfg_wr_data -> factor_eight_mask
//
// One word per cycle sustained while the queue is not full; a result is
// registered first in the queue and then in the output register.
// Per-module framing state is read and written in the same cycle, so words
// from one module may follow each other back to back.
// Reset clears all framing state and the factor mask at once; no sweep.
// A stalled output fills the two-entry queue, then in_ready drops.
module list_mode_event_deframer_top
    import lmed_pkg::*;
#(
    parameter int MODULES = MODULES_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [31:0]              cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [MOD_W-1:0]         source_module,
    input  logic [31:0]              data_word,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [MOD_W-1:0]         out_module,
    output logic [31:0]              header_word,
    output logic                     header_last,
    output logic [SCALED_TIME_W-1:0] scaled_time,
    output logic                     bad_header
);

    logic [31:0] factor_eight_mask_reg;
    logic        accept;
    logic        emit;
    lmed_entry_t entry;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    lmed_entry_t q_head;

    // Factor mask register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_eight_mask_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            factor_eight_mask_reg <= cfg_wr_data;
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    lmed_front #(
        .MODULES (MODULES)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .source_module     (source_module),
        .data_word         (data_word),
        .factor_eight_mask (factor_eight_mask_reg),
        .emit              (emit),
        .entry             (entry)
    );

    lmed_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && emit),
        .push_entry (entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    lmed_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_module  (out_module),
        .header_word (header_word),
        .header_last (header_last),
        .scaled_time (scaled_time),
        .bad_header  (bad_header)
    );

endmodule

// File: verif/deframer_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both word channels of the deframer, predicts
// the forwarded header words and compares them in order.
module deframer_checker
    import lmed_pkg::*;
#(
    parameter int MODULES = MODULES_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [31:0]              cfg_wr_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [MOD_W-1:0]         source_module,
    input  logic [31:0]              data_word,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [MOD_W-1:0]         out_module,
    input  logic [31:0]              header_word,
    input  logic                     header_last,
    input  logic [SCALED_TIME_W-1:0] scaled_time,
    input  logic                     bad_header,
    output int                       errors,
    output int                       pending
);

    typedef struct packed {
        logic [MOD_W-1:0]         module_id;
        logic [31:0]              word;
        logic                     last;
        logic [SCALED_TIME_W-1:0] stamp;
        logic                     bad;
    } header_result_t;

    // Per-module framing state as the block should hold it
    logic [EVLEN_W-1:0] next_pos   [MODULES];
    logic [EVLEN_W-1:0] event_len  [MODULES];
    logic [HDLEN_W-1:0] header_len [MODULES];
    logic [31:0]        stamp_low  [MODULES];
    logic [15:0]        stamp_high [MODULES];
    logic [31:0]        eight_mask;

    header_result_t expected_headers[$];
    header_result_t predicted;
    header_result_t exp_r;
    int             fail_cnt = 0;

    // Advance one module's framing by one word; returns 1 if a header word comes out
    function automatic bit deframe_word(input logic [MOD_W-1:0] m, input logic [31:0] w,
                                        output header_result_t r);
        logic [EVLEN_W-1:0] pos;
        logic [EVLEN_W-1:0] ev;
        logic [HDLEN_W-1:0] hd;
        logic [31:0]        word;
        logic [63:0]        raw;
        int                 nxt;
        r           = '0;
        r.module_id = m;
        word        = w;
        pos         = next_pos[m];

        // first word of an event
        if (pos == 0) begin
            ev = EVLEN_W'((w & EVLEN_MASK) >> EVLEN_SHIFT);
            hd = HDLEN_W'((w & HDLEN_MASK) >> HDLEN_SHIFT);
            if (ev == 0 || hd > ev) begin
                r.word = w;
                r.bad  = 1'b1;
                return 1'b1;
            end
            event_len[m]  = ev;
            header_len[m] = hd;
            stamp_low[m]  = '0;
            stamp_high[m] = '0;
            next_pos[m]   = (ev == 1) ? '0 : EVLEN_W'(1);
            if (hd == 0)
                return 1'b0;
            if (ev != hd)
                word = (32'(hd) << EVLEN_SHIFT) | (w & KEEP_MASK);
            r.word = word;
            r.last = (hd == 1);
            return 1'b1;
        end

        // header or trace word
        ev  = event_len[m];
        hd  = header_len[m];
        nxt = int'(pos) + 1;
        next_pos[m] = (nxt >= int'(ev)) ? '0 : EVLEN_W'(nxt);
        if (pos >= hd)
            return 1'b0;
        if (pos == 1)
            stamp_low[m] = w;
        else if (pos == 2)
            stamp_high[m] = w[15:0];
        else if (pos == 3 && ev != hd)
            word = w & LOW16_MASK;
        r.word = word;
        r.last = (nxt == int'(hd));
        if (r.last) begin
            raw     = {16'h0, stamp_high[m], stamp_low[m]};
            r.stamp = SCALED_TIME_W'(raw * (eight_mask[m] ? 64'd8 : 64'd10));
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < MODULES; i++) begin
                next_pos[i]   = '0;
                event_len[i]  = '0;
                header_len[i] = '0;
                stamp_low[i]  = '0;
                stamp_high[i] = '0;
            end
            eight_mask = '0;
            expected_headers.delete();
            pending <= 0;
        end
        else begin
            if (cfg_wr_en)
                eight_mask = cfg_wr_data;

            // compare an accepted result word with the oldest prediction
            if (out_valid && out_ready) begin
                if (expected_headers.size() == 0) begin
                    $error("result word for module %0d with nothing expected", out_module);
                    fail_cnt++;
                end
                else begin
                    exp_r = expected_headers.pop_front();
                    if (out_module !== exp_r.module_id) begin
                        $error("out_module: expected %0d, got %0d", exp_r.module_id, out_module);
                        fail_cnt++;
                    end
                    if (header_word !== exp_r.word) begin
                        $error("header_word: expected %h, got %h", exp_r.word, header_word);
                        fail_cnt++;
                    end
                    if (header_last !== exp_r.last) begin
                        $error("header_last: expected %b, got %b", exp_r.last, header_last);
                        fail_cnt++;
                    end
                    if (scaled_time !== exp_r.stamp) begin
                        $error("scaled_time: expected %h, got %h", exp_r.stamp, scaled_time);
                        fail_cnt++;
                    end
                    if (bad_header !== exp_r.bad) begin
                        $error("bad_header: expected %b, got %b", exp_r.bad, bad_header);
                        fail_cnt++;
                    end
                end
            end

            // predict from an accepted input word
            if (in_valid && in_ready) begin
                if (deframe_word(source_module, data_word, predicted))
                    expected_headers = {expected_headers, predicted};
            end

            pending <= expected_headers.size();
            errors  <= fail_cnt;
        end
    end

endmodule

// File: verif/list_mode_event_deframer_top_tb.sv
`timescale 1ns / 1ps

module list_mode_event_deframer_top_tb
    import lmed_pkg::*;
();

    localparam int HOLD_CYCLES = 300;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     cfg_wr_en     = 1'b0;
    logic [31:0]              cfg_wr_data   = '0;
    logic                     in_valid      = 1'b0;
    logic                     in_ready;
    logic [MOD_W-1:0]         source_module = '0;
    logic [31:0]              data_word     = '0;
    logic                     out_valid;
    logic                     out_ready     = 1'b0;
    logic [MOD_W-1:0]         out_module;
    logic [31:0]              header_word;
    logic                     header_last;
    logic [SCALED_TIME_W-1:0] scaled_time;
    logic                     bad_header;
    int                       errors;
    int                       pending;

    // sender/receiver idle rates in percent, receiver hold-off request
    int send_idle_pct = 37;
    int recv_idle_pct = 60;
    bit hold_request  = 1'b0;

    // words still due in the current event of each module
    int words_left [MODULES_DEFAULT];

    list_mode_event_deframer_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_module(source_module),
        .data_word    (data_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_module   (out_module),
        .header_word  (header_word),
        .header_last  (header_last),
        .scaled_time  (scaled_time),
        .bad_header   (bad_header)
    );

    deframer_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .source_module(source_module),
        .data_word    (data_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_module   (out_module),
        .header_word  (header_word),
        .header_last  (header_last),
        .scaled_time  (scaled_time),
        .bad_header   (bad_header),
        .errors       (errors),
        .pending      (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one word, wait for acceptance, track framing position
    task automatic send_word(input logic [MOD_W-1:0] m, input logic [31:0] w);
        int ev;
        int hd;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        source_module <= m;
        data_word     <= w;
        do @(posedge clk); while (!in_ready);
        if (words_left[m] > 0)
            words_left[m]--;
        else begin
            ev = w[29:17];
            hd = w[16:12];
            words_left[m] = (ev == 0 || hd > ev) ? 0 : ev - 1;
        end
    endtask

    // First word of an event with random filler bits
    function automatic logic [31:0] first_word(input int ev, input int hd);
        logic [31:0] w;
        w        = $urandom;
        w[29:17] = ev[12:0];
        w[16:12] = hd[4:0];
        return w;
    endfunction

    // Stop offering and wait until every predicted word has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mask(input logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly well-formed events with random content, some rejected first words
    task automatic run_random(input int n);
        logic [MOD_W-1:0] m;
        logic [31:0]      w;
        int               ev;
        int               hd;
        int               pick;
        repeat (n) begin
            m = MOD_W'($urandom_range(MODULES_DEFAULT - 1));
            w = $urandom;
            if (words_left[m] == 0) begin
                if ($urandom_range(99) < 12)
                    w[29:17] = 13'($urandom_range(12));
                else begin
                    pick = $urandom_range(99);
                    if (pick < 60)
                        ev = $urandom_range(1, 8);
                    else if (pick < 90)
                        ev = $urandom_range(9, 40);
                    else
                        ev = $urandom_range(41, 200);
                    if ($urandom_range(99) < 25)
                        hd = (ev < 31) ? ev : 31;
                    else
                        hd = $urandom_range(0, (ev < 31) ? ev : 31);
                    w = first_word(ev, hd);
                end
            end
            send_word(m, w);
        end
    endtask

    initial begin
        foreach (words_left[i])
            words_left[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rejected first words, empty and short headers, one-word events
        send_word(0, first_word(0, 0));
        send_word(1, first_word(2, 5));
        send_word(1, first_word(0, 31));
        send_word(2, first_word(1, 0));
        send_word(3, first_word(1, 1));
        send_word(4, first_word(3, 0));
        send_word(4, $urandom);
        send_word(4, $urandom);
        // full header kept, largest timestamp scaled by 10
        send_word(5, first_word(4, 4));
        send_word(5, '1);
        send_word(5, '1);
        send_word(5, '1);
        // trace stripped: length rewrite and word 3 masked
        send_word(6, first_word(6, 4));
        send_word(6, '0);
        send_word(6, $urandom);
        send_word(6, '1);
        send_word(6, $urandom);
        send_word(6, $urandom);
        // two-word header, upper timestamp bits stay zero
        send_word(31, first_word(5, 2));
        repeat (4) send_word(31, $urandom);

        // longest event with the longest header, scaled by 8; its trace
        // words trickle in during the random phases
        drain();
        write_mask(32'hFFFF_FFFF);
        send_word(9, first_word(8191, 31));
        send_word(9, '1);
        send_word(9, '1);
        repeat (28) send_word(9, $urandom);

        drain();
        write_mask($urandom);
        run_random(130);

        drain();
        write_mask(32'h0);
        send_idle_pct = 60;
        recv_idle_pct = 37;
        run_random(130);

        // no idling; long receiver hold-off, then a full pause
        drain();
        write_mask($urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(40);
        hold_request = 1'b1;
        run_random(60);
        drain();
        run_random(50);

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
